/* rtl/ufrw_pkg.sv */
// Shared types and constants of the UART FIFO register window.
package ufrw_pkg;

   typedef enum logic [1:0] {
      CMD_READ      = 2'd0,
      CMD_WRITE     = 2'd1,
      CMD_RX_ARRIVE = 2'd2,
      CMD_TX_DRAIN  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic [2:0] OFF_CONTROL = 3'd3;
   localparam logic [2:0] OFF_RX_DATA = 3'd4;
   localparam logic [2:0] OFF_RX_SIZE = 3'd5;
   localparam logic [2:0] OFF_TX_DATA = 3'd6;
   localparam logic [2:0] OFF_TX_SIZE = 3'd7;

   localparam logic [7:0] CTRL_RESET = 8'h05;
   localparam logic [7:0] CTRL_WMASK = 8'h3F;
   localparam logic [7:0] CTRL_TXOVF = 8'h40;
   localparam logic [7:0] CTRL_RXOVF = 8'h80;

   typedef struct packed {
      logic rd_en;
      logic push;
      logic pop;
   } fifo_op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

/* rtl/uart_fifo_register_window.sv */
// Top level of the UART register window with receive and transmit FIFOs.
// The accepting cycle of an item reads the head entry of both FIFO memories, and in the
// execute state, once the output register is free or is being taken, the block updates the
// registers, pointers and memories and loads the result register. A new item is accepted
// only once the block is back in its idle state, so no item is taken before the last one has
// finished; the registered read data of the FIFO memories is why the work is split this way.
// A finished result waits in its output register while the next item is accepted.
module uart_fifo_register_window #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_value,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_crlf_enable,
   output logic       rsp_flow_enable,
   output logic [1:0] rsp_charset_select
);
   import ufrw_pkg::*;

   localparam int CW   = $clog2(FIFO_DEPTH + 1);
   localparam int SATW = (CW > 8) ? CW : 8;

   function automatic logic [7:0] sat8(input logic [CW-1:0] v);
      logic [SATW-1:0] w;
      w = SATW'(v);
      return (w > SATW'(255)) ? 8'hFF : w[7:0];
   endfunction

   state_type  state_ff, state_in;
   cmd_type    cmd_ff;
   logic [2:0] off_ff;
   logic [7:0] data_ff;

   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] rx_head_ff, rx_head_in;
   logic [7:0] rx_size_ff, rx_size_in;
   logic [7:0] tx_data_ff, tx_data_in;
   logic [7:0] tx_size_ff, tx_size_in;

   logic       rsp_valid_ff;
   logic [7:0] rsp_read_value_ff, rsp_read_value_in;
   logic       rsp_tx_valid_ff, rsp_tx_valid_in;
   logic [7:0] rsp_tx_byte_ff, rsp_tx_byte_in;
   logic [7:0] rsp_ctrl_ff;

   logic          accept;
   logic          finish;
   fifo_op_type   rx_op, tx_op;
   fifo_stat_type rx_stat, tx_stat;
   logic [7:0]    rx_head_data, tx_head_data;
   logic [CW-1:0] rx_count, tx_count;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rx_op.rd_en = accept;
      tx_op.rd_en = accept;
      rx_op.pop   = finish && (cmd_ff == CMD_READ) && (off_ff == OFF_RX_DATA) && !rx_stat.empty;
      rx_op.push  = finish && (cmd_ff == CMD_RX_ARRIVE) && !rx_stat.full;
      tx_op.pop   = finish && (cmd_ff == CMD_TX_DRAIN) && !tx_stat.empty;
      tx_op.push  = finish && (cmd_ff == CMD_WRITE) && (off_ff == OFF_TX_DATA) && !tx_stat.full;
   end

   always_comb begin
      ctrl_in           = ctrl_ff;
      rx_head_in        = rx_head_ff;
      rx_size_in        = rx_size_ff;
      tx_data_in        = tx_data_ff;
      tx_size_in        = tx_size_ff;
      rsp_read_value_in = 8'h00;
      rsp_tx_valid_in   = 1'b0;
      rsp_tx_byte_in    = 8'h00;
      unique case (cmd_ff)
         CMD_READ: begin
            unique case (off_ff)
               OFF_CONTROL: begin
                  rsp_read_value_in = ctrl_ff;
                  ctrl_in           = ctrl_ff & CTRL_WMASK;
               end
               OFF_RX_DATA: begin
                  rsp_read_value_in = rx_head_ff;
                  if (rx_stat.empty) begin
                     rx_head_in = 8'h00;
                     rx_size_in = 8'h00;
                  end else begin
                     rx_head_in = rx_head_data;
                     rx_size_in = sat8(rx_count);
                  end
               end
               OFF_RX_SIZE: rsp_read_value_in = rx_size_ff;
               OFF_TX_DATA: rsp_read_value_in = tx_data_ff;
               OFF_TX_SIZE: rsp_read_value_in = tx_size_ff;
               default:     rsp_read_value_in = 8'h00;
            endcase
         end
         CMD_WRITE: begin
            if (off_ff == OFF_CONTROL) begin
               ctrl_in = data_ff & CTRL_WMASK;
            end else if (off_ff == OFF_TX_DATA) begin
               tx_data_in = data_ff;
               if (tx_stat.full) begin
                  ctrl_in = ctrl_ff | CTRL_TXOVF;
               end else begin
                  tx_size_in = sat8(CW'(tx_count + 1'b1));
               end
            end
         end
         CMD_RX_ARRIVE: begin
            if (rx_stat.full) begin
               ctrl_in = ctrl_ff | CTRL_RXOVF;
            end
         end
         CMD_TX_DRAIN: begin
            if (!tx_stat.empty) begin
               rsp_tx_valid_in = 1'b1;
               rsp_tx_byte_in  = tx_head_data;
               tx_size_in      = sat8(CW'(tx_count - 1'b1));
            end
         end
         default: begin
            ctrl_in = ctrl_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_ff      <= CTRL_RESET;
         rx_head_ff   <= 8'h00;
         rx_size_ff   <= 8'h00;
         tx_data_ff   <= 8'h00;
         tx_size_ff   <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            ctrl_ff      <= ctrl_in;
            rx_head_ff   <= rx_head_in;
            rx_size_ff   <= rx_size_in;
            tx_data_ff   <= tx_data_in;
            tx_size_ff   <= tx_size_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_command);
         off_ff  <= req_reg_offset;
         data_ff <= req_data_byte;
      end
      if (finish) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_tx_valid_ff   <= rsp_tx_valid_in;
         rsp_tx_byte_ff    <= rsp_tx_byte_in;
         rsp_ctrl_ff       <= ctrl_in;
      end
   end

   ufrw_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .op        (rx_op),
      .push_data (data_ff),
      .head_data (rx_head_data),
      .count     (rx_count),
      .stat      (rx_stat)
   );

   ufrw_fifo #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .op        (tx_op),
      .push_data (data_ff),
      .head_data (tx_head_data),
      .count     (tx_count),
      .stat      (tx_stat)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_tx_valid       = rsp_tx_valid_ff;
   assign rsp_tx_byte        = rsp_tx_byte_ff;
   assign rsp_crlf_enable    = rsp_ctrl_ff[0];
   assign rsp_flow_enable    = rsp_ctrl_ff[1];
   assign rsp_charset_select = rsp_ctrl_ff[3:2];

endmodule

/* rtl/ufrw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ufrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ufrw_fifo.sv */
// Byte FIFO: read and write pointers, fill count and its storage RAM.
module ufrw_fifo #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ufrw_pkg::fifo_op_type           op,
   input  logic [7:0]                      push_data,
   output logic [7:0]                      head_data,
   output logic [$clog2(FIFO_DEPTH+1)-1:0] count,
   output ufrw_pkg::fifo_stat_type         stat
);
   import ufrw_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (op.push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
         count_in  = CW'(count_ff + 1'b1);
      end
      if (op.pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
         count_in  = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   ufrw_ram #(
      .WIDTH(8),
      .DEPTH(FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (op.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_en   (op.rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (head_data)
   );

   assign count      = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(FIFO_DEPTH));

endmodule
